>>> hdl/mips_pkg.sv
// ----------------------------------------------------------------------------
// MIPS subset executor package
// Shared types, opcodes and constants of the instruction executor.
// ----------------------------------------------------------------------------
package mips_pkg;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_TRAP    = 6'h1a;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2b;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_DIV  = 6'h1a;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_SLT  = 6'h2a;

    localparam logic [3:0] TRAP_NEWLINE = 4'h0;
    localparam logic [3:0] TRAP_PRINT   = 4'h1;
    localparam logic [3:0] TRAP_READ    = 4'h5;

    localparam logic [1:0] PK_NONE    = 2'd0;
    localparam logic [1:0] PK_NEWLINE = 2'd1;
    localparam logic [1:0] PK_PRINT   = 2'd2;
    localparam logic [1:0] PK_READ    = 2'd3;

    localparam logic [31:0] GP_INIT   = 32'h1000_8000;
    localparam logic [31:0] DATA_BASE = 32'h1000_0000;
    localparam logic [4:0]  REG_GP    = 5'd28;
    localparam logic [4:0]  REG_SP    = 5'd29;
    localparam logic [4:0]  REG_RA    = 5'd31;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_STACK = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_A,
        ST_READ_B,
        ST_EXEC,
        ST_DIV,
        ST_MEM,
        ST_WB,
        ST_OUT
    } state_t;

    // Divider command and status.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [31:0] remainder;
    } div_stat_t;

endpackage

>>> hdl/mips_ram.sv
// ----------------------------------------------------------------------------
// MIPS generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module mips_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/mips_div.sv
// ----------------------------------------------------------------------------
// MIPS iterative divider
// Signed 32-bit restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mips_div (
    input  logic                clk,
    input  logic                rst_n,
    input  mips_pkg::div_cmd_t  cmd,
    output mips_pkg::div_stat_t stat
);
    import mips_pkg::*;

    logic        busy_reg, busy_next;
    logic        fix_reg, fix_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        negq_reg, negq_next;
    logic        negr_reg, negr_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb
    begin
        busy_next = busy_reg;
        fix_next  = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[31]};
        trial     = shifted - {1'b0, dvs_reg};
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            quo_next  = cmd.dividend[31] ? 32'd0 - cmd.dividend : cmd.dividend;
            dvs_next  = cmd.divisor[31] ? 32'd0 - cmd.divisor : cmd.divisor;
            rem_next  = 32'd0;
            negq_next = cmd.dividend[31] ^ cmd.divisor[31];
            negr_next = cmd.dividend[31];
        end
        else if (busy_reg)
        begin
            if (trial[32])
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end
        else if (fix_reg)
        begin
            if (negq_reg)
            begin
                quo_next = 32'd0 - quo_reg;
            end
            if (negr_reg)
            begin
                rem_next = 32'd0 - rem_reg;
            end
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    assign stat.done      = done_reg;
    assign stat.quotient  = quo_reg;
    assign stat.remainder = rem_reg;

endmodule

>>> hdl/mips_subset_instruction_executor.sv
// ----------------------------------------------------------------------------
// MIPS subset instruction executor
// Executes one instruction word per transfer and reports the next pc.
// ----------------------------------------------------------------------------
// Division by a nonzero divisor runs the one-bit-per-cycle divider, and
// lw adds a memory read state before write-back. One instruction is in
// flight at a time and the next transfer can be taken from the cycle after
// the result transfer. Reset clears control state and then sweeps addresses
// 0 through max(DATA_WORDS, 32) - 1 to zero the data memory and load the
// register file before taking input.
module mips_subset_instruction_executor #(
    parameter int DATA_WORDS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] instruction, [63:32] console_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] next_pc, [32] halted,
                                   // [34:33] print_kind, [66:35] print_value,
                                   // [67] bad_instruction, [71:68] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import mips_pkg::*;

    localparam int AW  = $clog2(DATA_WORDS);
    localparam int CW  = (AW > 5) ? AW : 5;
    localparam int CLR_LAST = (DATA_WORDS > 32) ? DATA_WORDS - 1 : 31;

    state_t state_reg, state_next;

    logic [31:0] stack_reg;
    logic        fresh_reg;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] hi_reg, lo_reg;
    logic        stop_reg;
    logic [CW:0] clr_reg;
    logic [31:0] ins_reg, cval_reg;
    logic [31:0] a_reg, b_reg;
    logic [31:0] wb_val_reg;
    logic [4:0]  wb_dst_reg;
    logic        wb_en_reg, wb_mem_reg;
    logic [71:0] out_reg;
    logic        out_valid_reg;

    // decode
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] uimm, simm;
    assign op   = ins_reg[31:26];
    assign rs   = ins_reg[25:21];
    assign rt   = ins_reg[20:16];
    assign rd   = ins_reg[15:11];
    assign sh   = ins_reg[10:6];
    assign fn   = ins_reg[5:0];
    assign uimm = {16'd0, ins_reg[15:0]};
    assign simm = {{16{ins_reg[15]}}, ins_reg[15:0]};

    // register file RAM
    logic       rf_we;
    logic [4:0] rf_waddr, rf_raddr;
    logic [31:0] rf_wdata, rf_rdata;
    mips_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
        .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(rf_raddr), .rdata(rf_rdata)
    );

    // data memory RAM
    logic          dm_we;
    logic [AW-1:0] dm_waddr, dm_raddr;
    logic [31:0]   dm_wdata, dm_rdata;
    mips_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dm (
        .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
        .raddr(dm_raddr), .rdata(dm_rdata)
    );

    div_cmd_t  dcmd;
    div_stat_t dstat;
    mips_div u_div (.clk(clk), .rst_n(rst_n), .cmd(dcmd), .stat(dstat));

    // address of a load/store, word index and range check
    logic [31:0] maddr, mword;
    logic        min_range;
    assign maddr     = a_reg + simm;
    assign mword     = (maddr - DATA_BASE) >> 2;
    assign min_range = (mword < 32'(DATA_WORDS));

    logic [63:0] prod;
    assign prod = $signed(a_reg) * $signed(b_reg);

    logic [31:0] pc4;
    assign pc4 = pc_reg + 32'd4;

    assign s_tready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready = (state_reg != ST_CLEAR);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == (CW+1)'(CLR_LAST)) state_next = ST_IDLE;
            ST_IDLE:   if (s_tvalid && s_tready) state_next = stop_reg ? ST_OUT : ST_READ_A;
            ST_READ_A: state_next = ST_READ_B;
            ST_READ_B: state_next = ST_EXEC;
            ST_EXEC:
                if (op == OP_SPECIAL && fn == FN_DIV && b_reg != 32'd0)
                    state_next = ST_DIV;
                else if (op == OP_LW)
                    state_next = ST_MEM;
                else
                    state_next = ST_WB;
            ST_DIV:    if (dstat.done) state_next = ST_WB;
            ST_MEM:    state_next = ST_WB;
            ST_WB:     state_next = ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        rf_raddr = rs;
        rf_we    = 1'b0;
        rf_waddr = wb_dst_reg;
        rf_wdata = wb_mem_reg ? dm_rdata : wb_val_reg;
        dm_we    = 1'b0;
        dm_waddr = mword[AW-1:0];
        dm_wdata = b_reg;
        dm_raddr = mword[AW-1:0];
        dcmd.start    = 1'b0;
        dcmd.dividend = a_reg;
        dcmd.divisor  = b_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                dm_we    = (clr_reg < (CW+1)'(DATA_WORDS));
                dm_waddr = clr_reg[AW-1:0];
                dm_wdata = 32'd0;
                rf_we    = (clr_reg < (CW+1)'(32));
                rf_waddr = clr_reg[4:0];
                rf_wdata = (clr_reg[4:0] == REG_GP) ? GP_INIT :
                           (clr_reg[4:0] == REG_SP) ? stack_reg : 32'd0;
            end
            // rs is addressed straight from the input so that its data is
            // there in ST_READ_A, and rt is addressed in ST_READ_A for ST_READ_B.
            ST_IDLE:   rf_raddr = s_tdata[25:21];
            ST_READ_A: rf_raddr = rt;
            ST_EXEC:
            begin
                dcmd.start = (op == OP_SPECIAL && fn == FN_DIV && b_reg != 32'd0);
                dm_we = (op == OP_SW) && min_range;
            end
            ST_WB:     rf_we = wb_en_reg && (wb_dst_reg != 5'd0);
            default:   ;
        endcase
        if (state_reg == ST_IDLE && cfg_valid && cfg_ready && cfg_index == CFG_STACK &&
            fresh_reg)
        begin
            rf_we    = 1'b1;
            rf_waddr = REG_SP;
            rf_wdata = cfg_data;
        end
    end

    // execute
    logic [31:0] ex_val;
    logic [4:0]  ex_dst;
    logic        ex_en, ex_bad, ex_stop, ex_mem;
    logic [1:0]  ex_kind;
    logic [31:0] ex_pval;
    logic        hl_we;
    logic [31:0] hi_new, lo_new;
    always_comb
    begin
        ex_val  = 32'd0;
        ex_dst  = rd;
        ex_en   = 1'b0;
        ex_bad  = 1'b0;
        ex_stop = 1'b0;
        ex_mem  = 1'b0;
        ex_kind = PK_NONE;
        ex_pval = 32'd0;
        pc_next = pc4;
        hl_we   = 1'b0;
        hi_new  = hi_reg;
        lo_new  = lo_reg;
        unique case (op)
            OP_SPECIAL:
                unique case (fn)
                    FN_SLL:  begin ex_en = 1'b1; ex_val = b_reg << sh; end
                    FN_SRA:  begin ex_en = 1'b1; ex_val = $signed(b_reg) >>> sh; end
                    FN_JR:   pc_next = a_reg;
                    FN_MFHI: begin ex_en = 1'b1; ex_val = hi_reg; end
                    FN_MFLO: begin ex_en = 1'b1; ex_val = lo_reg; end
                    FN_MULT: begin hl_we = 1'b1; hi_new = prod[63:32]; lo_new = prod[31:0]; end
                    FN_DIV:
                        if (b_reg == 32'd0)
                        begin
                            hl_we = 1'b1; hi_new = a_reg; lo_new = 32'hffff_ffff;
                        end
                    FN_ADDU: begin ex_en = 1'b1; ex_val = a_reg + b_reg; end
                    FN_SUBU: begin ex_en = 1'b1; ex_val = a_reg - b_reg; end
                    FN_SLT:  begin ex_en = 1'b1; ex_val = {31'd0, $signed(a_reg) < $signed(b_reg)}; end
                    default: ex_bad = 1'b1;
                endcase
            OP_J:   pc_next = {pc4[31:28], ins_reg[25:0], 2'b00};
            OP_JAL:
            begin
                ex_en = 1'b1; ex_dst = REG_RA; ex_val = pc4;
                pc_next = {pc4[31:28], ins_reg[25:0], 2'b00};
            end
            OP_BEQ:   if (a_reg == b_reg) pc_next = pc4 + {simm[29:0], 2'b00};
            OP_BNE:   if (a_reg != b_reg) pc_next = pc4 + {simm[29:0], 2'b00};
            OP_ADDIU: begin ex_en = 1'b1; ex_dst = rt; ex_val = a_reg + simm; end
            OP_ANDI:  begin ex_en = 1'b1; ex_dst = rt; ex_val = a_reg & uimm; end
            OP_LUI:   begin ex_en = 1'b1; ex_dst = rt; ex_val = {ins_reg[15:0], 16'd0}; end
            OP_TRAP:
                unique case (ins_reg[3:0])
                    TRAP_NEWLINE: ex_kind = PK_NEWLINE;
                    TRAP_PRINT:   begin ex_kind = PK_PRINT; ex_pval = a_reg; end
                    TRAP_READ:
                    begin
                        ex_kind = PK_READ; ex_en = 1'b1; ex_dst = rt; ex_val = cval_reg;
                    end
                    default:      ex_stop = 1'b1;
                endcase
            OP_LW:
            begin
                ex_en = 1'b1; ex_dst = rt; ex_mem = min_range; ex_val = 32'd0;
            end
            OP_SW:    ;
            default:  ex_bad = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            stack_reg     <= 32'h1000_1000;
            pc_reg        <= 32'h0040_0000;
            fresh_reg     <= 1'b1;
            hi_reg        <= 32'd0;
            lo_reg        <= 32'd0;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + (CW+1)'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_START)
                begin
                    if (fresh_reg)
                    begin
                        pc_reg <= cfg_data;
                    end
                end
                else
                begin
                    stack_reg <= cfg_data;
                end
            end
            if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE && s_tvalid && s_tready)
            begin
                fresh_reg <= 1'b0;
                if (stop_reg)
                begin
                    out_reg <= {4'd0, 1'b0, 32'd0, PK_NONE, 1'b1, pc_reg};
                end
            end
            if (state_reg == ST_EXEC)
            begin
                pc_reg <= pc_next;
                if (hl_we)
                begin
                    hi_reg <= hi_new;
                    lo_reg <= lo_new;
                end
                if (ex_stop)
                begin
                    stop_reg <= 1'b1;
                end
                out_reg <= {4'd0, ex_bad, ex_pval, ex_kind, ex_stop, pc_next};
            end
            if (state_reg == ST_DIV && dstat.done)
            begin
                hi_reg <= dstat.remainder;
                lo_reg <= dstat.quotient;
            end
            if (state_reg == ST_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid && s_tready)
        begin
            ins_reg  <= s_tdata[31:0];
            cval_reg <= s_tdata[63:32];
        end
        if (state_reg == ST_READ_A)
        begin
            a_reg <= (rs == 5'd0) ? 32'd0 : rf_rdata;
        end
        // rt data arrives the cycle after ST_READ_A issues its address.
        if (state_reg == ST_READ_B)
        begin
            b_reg <= (rt == 5'd0) ? 32'd0 : rf_rdata;
        end
        if (state_reg == ST_EXEC)
        begin
            wb_val_reg <= ex_val;
            wb_dst_reg <= ex_dst;
            wb_en_reg  <= ex_en;
            wb_mem_reg <= ex_mem;
        end
    end

endmodule

>>> hdl/mips_checker.sv
// ----------------------------------------------------------------------------
// MIPS executor port checker
// Checks handshake and result rules seen at the top-level ports.
// ----------------------------------------------------------------------------
module mips_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second instruction taken while busy");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[32] |-> !m_tdata[67])
        else $error("halt reported with bad instruction");

endmodule

bind mips_subset_instruction_executor mips_checker u_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
